// ===== rtl/core/bdma_pkg.sv =====
// ----------------------------------------------------------------------------
// BLER-driven MCS adapter: shared definitions
// Widths, constants, register map and shared types of the adapter.
// ----------------------------------------------------------------------------
package bdma_pkg;

  localparam int unsigned COUNT_WIDTH = 32;
  localparam int unsigned FRAME_W     = 10;
  localparam int unsigned MCS_W       = 5;
  localparam int unsigned Q_BITS      = 16;
  localparam int unsigned STEP_W      = $clog2(Q_BITS);
  localparam int unsigned ACC_W       = 2 * Q_BITS;
  localparam int unsigned PADDR_W     = 5;
  localparam int unsigned PDATA_W     = 32;

  localparam logic [MCS_W-1:0]  SEED_MCS     = MCS_W'(9);
  localparam logic [MCS_W-1:0]  MCS_FLOOR    = MCS_W'(6);
  localparam int unsigned       MIN_ACTIVITY = 3;
  localparam logic [Q_BITS:0]   ONE_Q16      = {1'b1, {Q_BITS{1'b0}}};
  localparam logic [ACC_W-1:0]  ROUND_HALF   = ACC_W'(1) << (Q_BITS - 1);
  localparam logic [Q_BITS-1:0] WIN_SAT      = {Q_BITS{1'b1}};
  localparam logic [Q_BITS-1:0] WIN_ZERO     = '0;

  localparam logic [Q_BITS-1:0]  RST_BLER_LOWER      = 16'd3277;
  localparam logic [Q_BITS-1:0]  RST_BLER_UPPER      = 16'd9830;
  localparam logic [MCS_W-1:0]   RST_MCS_CAP         = 5'd28;
  localparam logic [FRAME_W-1:0] RST_UPDATE_INTERVAL = 10'd10;
  localparam logic [Q_BITS-1:0]  RST_FILTER_WEIGHT   = 16'd58982;

  typedef enum logic [2:0] {
    REG_BLER_LOWER      = 3'd0,
    REG_BLER_UPPER      = 3'd1,
    REG_MCS_CAP         = 3'd2,
    REG_UPDATE_INTERVAL = 3'd3,
    REG_FILTER_WEIGHT   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [Q_BITS-1:0]  bler_lower;
    logic [Q_BITS-1:0]  bler_upper;
    logic [MCS_W-1:0]   mcs_cap;
    logic [FRAME_W-1:0] update_interval;
    logic [Q_BITS-1:0]  filter_weight;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic step;
  } ser_ctrl_t;

endpackage

// ===== rtl/core/bler_driven_mcs_adapter.sv =====
// ----------------------------------------------------------------------------
// BLER-driven MCS adapter
// Link adaptation that filters the measured block error rate and steps the
// MCS index against lower and upper BLER targets.
// ----------------------------------------------------------------------------
// Each input item carries a frame number, a per-call MCS ceiling and the
// running counts of first transmissions and retransmissions; each item gives
// exactly one result item with the MCS to use, an update flag and the
// filtered BLER. Both channels use valid and ready. Targets, the MCS cap, the
// update interval and the filter weight are written over the APB port; the
// user must write them only while the block is idle, which it does not enforce.
// An item inside the update interval has its result registered in the setup
// state. An update item goes from setup to the serial ratio unit, which
// delivers one quotient bit per cycle into the serial filter accumulator,
// and then to a finish state that rounds and steps the MCS. The controller
// returns to idle as the result is registered and accepts the next item there.
// The result waits in an output register, so the next item is accepted while
// the receiver stalls; a second result waits for that register to drain.
// Reset clears the adaptation state and the output register and restores the
// register defaults.
// ----------------------------------------------------------------------------
module bler_driven_mcs_adapter #(
  parameter int unsigned COUNT_WIDTH = bdma_pkg::COUNT_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bdma_pkg::PADDR_W-1:0]  paddr,
  input  logic [bdma_pkg::PDATA_W-1:0]  pwdata,
  output logic [bdma_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bdma_pkg::FRAME_W-1:0]  frame_number,
  input  logic [bdma_pkg::MCS_W-1:0]    mcs_ceiling,
  input  logic [COUNT_WIDTH-1:0]        sched_count,
  input  logic [COUNT_WIDTH-1:0]        retx_count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bdma_pkg::MCS_W-1:0]    mcs_out,
  output logic                          was_updated,
  output logic [bdma_pkg::Q_BITS-1:0]   bler_average
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_PREP   = 4'b0010,
    ST_RUN    = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  bdma_pkg::cfg_t      cfg;
  bdma_pkg::ser_ctrl_t ser_ctrl;

  logic [bdma_pkg::FRAME_W-1:0] last_update_frame;
  logic [bdma_pkg::MCS_W-1:0]   current_mcs;
  logic [bdma_pkg::Q_BITS-1:0]  filtered_bler;
  logic [COUNT_WIDTH-1:0]       sched_snapshot;
  logic [COUNT_WIDTH-1:0]       retx_snapshot;

  logic [bdma_pkg::FRAME_W-1:0] frame_r;
  logic [bdma_pkg::MCS_W-1:0]   ceil_r;
  logic [COUNT_WIDTH-1:0]       sched_r;
  logic [COUNT_WIDTH-1:0]       retx_r;
  logic [COUNT_WIDTH-1:0]       ns_r;
  logic [COUNT_WIDTH-1:0]       nr_r;
  logic [bdma_pkg::MCS_W-1:0]   old_r;
  logic [bdma_pkg::MCS_W-1:0]   cap_r;
  logic                         active_r;
  logic [bdma_pkg::STEP_W-1:0]  step_cnt;

  logic                         in_fire;
  logic                         out_free;
  logic                         seeded;
  logic [bdma_pkg::FRAME_W-1:0] lf_eff;
  logic [bdma_pkg::MCS_W-1:0]   cm_eff;
  logic [bdma_pkg::Q_BITS-1:0]  fb_eff;
  logic [bdma_pkg::Q_BITS:0]    mid_sum;
  logic [bdma_pkg::FRAME_W-1:0] gap;
  logic [bdma_pkg::MCS_W-1:0]   cap;
  logic [bdma_pkg::MCS_W-1:0]   old;
  logic                         no_update;
  logic                         ns_pos;
  logic                         active;
  logic                         preset_en;
  logic [bdma_pkg::Q_BITS-1:0]  preset_val;
  logic                         qbit;
  logic [bdma_pkg::Q_BITS-1:0]  bler_new;
  logic                         mcs_up;
  logic                         mcs_down;
  logic [bdma_pkg::MCS_W-1:0]   mcs_next;

  bdma_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // A zero frame and zero MCS mark state that has never been seeded.
  assign seeded  = (last_update_frame == '0) && (current_mcs == '0);
  assign mid_sum = {1'b0, cfg.bler_lower} + {1'b0, cfg.bler_upper};
  assign lf_eff  = seeded ? frame_r : last_update_frame;
  assign cm_eff  = seeded ? bdma_pkg::SEED_MCS : current_mcs;
  assign fb_eff  = seeded ? mid_sum[bdma_pkg::Q_BITS:1] : filtered_bler;

  assign gap       = frame_r - lf_eff;
  assign cap       = (ceil_r < cfg.mcs_cap) ? ceil_r : cfg.mcs_cap;
  assign old       = (cm_eff < cap) ? cm_eff : cap;
  assign no_update = (gap < cfg.update_interval);

  assign ns_pos = !ns_r[COUNT_WIDTH-1] && (ns_r != '0);
  assign active = ns_pos && (ns_r > COUNT_WIDTH'(bdma_pkg::MIN_ACTIVITY));

  assign preset_en = !ns_pos || nr_r[COUNT_WIDTH-1] || (nr_r >= ns_r);

  always_comb begin
    if (!ns_pos) begin
      preset_val = fb_eff;
    end else if (nr_r[COUNT_WIDTH-1]) begin
      preset_val = bdma_pkg::WIN_ZERO;
    end else begin
      preset_val = bdma_pkg::WIN_SAT;
    end
  end

  assign ser_ctrl.start = (state == ST_PREP) && !no_update;
  assign ser_ctrl.step  = (state == ST_RUN);

  bdma_serial_div #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ser_ctrl),
    .preset_en (preset_en),
    .preset    (preset_val),
    .num       (nr_r),
    .den       (ns_r),
    .qbit      (qbit)
  );

  bdma_serial_mac u_mac (
    .clk      (clk),
    .ctrl     (ser_ctrl),
    .weight   (cfg.filter_weight),
    .bler_old (fb_eff),
    .qbit     (qbit),
    .bler_new (bler_new)
  );

  assign mcs_up   = (bler_new < cfg.bler_lower) && (old_r < cap_r) && active_r;
  assign mcs_down = ((bler_new > cfg.bler_upper) && (old_r > bdma_pkg::MCS_FLOOR)) ||
                    (!active_r && (old_r > bdma_pkg::SEED_MCS));

  always_comb begin
    if (mcs_up) begin
      mcs_next = old_r + bdma_pkg::MCS_W'(1);
    end else if (mcs_down) begin
      mcs_next = old_r - bdma_pkg::MCS_W'(1);
    end else begin
      mcs_next = old_r;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        if (!no_update) begin
          state_next = ST_RUN;
        end else if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_RUN: begin
        if (step_cnt == bdma_pkg::STEP_W'(bdma_pkg::Q_BITS - 1)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      step_cnt          <= '0;
      out_valid         <= 1'b0;
      last_update_frame <= '0;
      current_mcs       <= '0;
      filtered_bler     <= '0;
      sched_snapshot    <= '0;
      retx_snapshot     <= '0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == ST_PREP) begin
        step_cnt          <= '0;
        last_update_frame <= lf_eff;
        current_mcs       <= cm_eff;
        filtered_bler     <= fb_eff;
        if (no_update && out_free) begin
          out_valid <= 1'b1;
        end
      end
      if (state == ST_RUN) begin
        step_cnt <= step_cnt + bdma_pkg::STEP_W'(1);
      end
      if ((state == ST_FINISH) && out_free) begin
        out_valid         <= 1'b1;
        last_update_frame <= frame_r;
        current_mcs       <= mcs_next;
        filtered_bler     <= bler_new;
        sched_snapshot    <= sched_r;
        retx_snapshot     <= retx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      frame_r <= frame_number;
      ceil_r  <= mcs_ceiling;
      sched_r <= sched_count;
      retx_r  <= retx_count;
      ns_r    <= sched_count - sched_snapshot;
      nr_r    <= retx_count - retx_snapshot;
    end
    if (state == ST_PREP) begin
      old_r    <= old;
      cap_r    <= cap;
      active_r <= active;
      if (no_update && out_free) begin
        mcs_out      <= old;
        was_updated  <= 1'b0;
        bler_average <= fb_eff;
      end
    end
    if ((state == ST_FINISH) && out_free) begin
      mcs_out      <= mcs_next;
      was_updated  <= 1'b1;
      bler_average <= bler_new;
    end
  end

  a_accept_to_prep: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state == ST_PREP))
    else $error("Accepted item did not move the controller to setup.");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_PREP || $past(state) == ST_FINISH))
    else $error("Result appeared outside setup or finish.");

  a_run_length: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) && (step_cnt == bdma_pkg::STEP_W'(bdma_pkg::Q_BITS - 1))
      |=> (state == ST_FINISH))
    else $error("Serial run did not end after the full quotient width.");

  a_mcs_within_cap: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH) && out_free |=> (mcs_out <= $past(cap_r)) && was_updated)
    else $error("Updated MCS exceeds the effective cap.");

endmodule

// ===== rtl/core/bdma_apb_regs.sv =====
// ----------------------------------------------------------------------------
// BLER-driven MCS adapter: configuration registers
// APB-style register file holding the targets, cap, interval and weight.
// ----------------------------------------------------------------------------
module bdma_apb_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bdma_pkg::PADDR_W-1:0]    paddr,
  input  logic [bdma_pkg::PDATA_W-1:0]    pwdata,
  output logic [bdma_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready,
  output bdma_pkg::cfg_t                  cfg
);

  bdma_pkg::reg_idx_t idx;
  logic               wr_en;

  assign idx    = bdma_pkg::reg_idx_t'(paddr[bdma_pkg::PADDR_W-1:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bler_lower      <= bdma_pkg::RST_BLER_LOWER;
      cfg.bler_upper      <= bdma_pkg::RST_BLER_UPPER;
      cfg.mcs_cap         <= bdma_pkg::RST_MCS_CAP;
      cfg.update_interval <= bdma_pkg::RST_UPDATE_INTERVAL;
      cfg.filter_weight   <= bdma_pkg::RST_FILTER_WEIGHT;
    end else if (wr_en) begin
      case (idx)
        bdma_pkg::REG_BLER_LOWER:      cfg.bler_lower      <= pwdata[bdma_pkg::Q_BITS-1:0];
        bdma_pkg::REG_BLER_UPPER:      cfg.bler_upper      <= pwdata[bdma_pkg::Q_BITS-1:0];
        bdma_pkg::REG_MCS_CAP:         cfg.mcs_cap         <= pwdata[bdma_pkg::MCS_W-1:0];
        bdma_pkg::REG_UPDATE_INTERVAL: cfg.update_interval <= pwdata[bdma_pkg::FRAME_W-1:0];
        bdma_pkg::REG_FILTER_WEIGHT:   cfg.filter_weight   <= pwdata[bdma_pkg::Q_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      bdma_pkg::REG_BLER_LOWER:      prdata = bdma_pkg::PDATA_W'(cfg.bler_lower);
      bdma_pkg::REG_BLER_UPPER:      prdata = bdma_pkg::PDATA_W'(cfg.bler_upper);
      bdma_pkg::REG_MCS_CAP:         prdata = bdma_pkg::PDATA_W'(cfg.mcs_cap);
      bdma_pkg::REG_UPDATE_INTERVAL: prdata = bdma_pkg::PDATA_W'(cfg.update_interval);
      bdma_pkg::REG_FILTER_WEIGHT:   prdata = bdma_pkg::PDATA_W'(cfg.filter_weight);
      default:                       prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/bdma_serial_div.sv =====
// ----------------------------------------------------------------------------
// BLER-driven MCS adapter: serial ratio unit
// Restoring divider that yields one Q0.16 quotient bit per cycle, MSB first,
// or shifts out a preset ratio for the saturated, zero and bypass cases.
// ----------------------------------------------------------------------------
module bdma_serial_div #(
  parameter int unsigned COUNT_WIDTH = bdma_pkg::COUNT_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  bdma_pkg::ser_ctrl_t          ctrl,
  input  logic                         preset_en,
  input  logic [bdma_pkg::Q_BITS-1:0]  preset,
  input  logic [COUNT_WIDTH-1:0]       num,
  input  logic [COUNT_WIDTH-1:0]       den,
  output logic                         qbit
);

  logic [COUNT_WIDTH-1:0]      rem;
  logic [COUNT_WIDTH-1:0]      den_r;
  logic [bdma_pkg::Q_BITS-1:0] preset_sr;
  logic                        use_preset;
  logic [COUNT_WIDTH-1:0]      rem2;
  logic                        q_div;

  // The remainder stays below a positive divisor, so its top bit is clear.
  assign rem2  = {rem[COUNT_WIDTH-2:0], 1'b0};
  assign q_div = (rem2 >= den_r);
  assign qbit  = use_preset ? preset_sr[bdma_pkg::Q_BITS-1] : q_div;

  always_ff @(posedge clk) begin
    if (rst) begin
      use_preset <= 1'b1;
    end else if (ctrl.start) begin
      use_preset <= preset_en;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem       <= num;
      den_r     <= den;
      preset_sr <= preset;
    end else if (ctrl.step) begin
      rem       <= q_div ? (rem2 - den_r) : rem2;
      preset_sr <= {preset_sr[bdma_pkg::Q_BITS-2:0], 1'b0};
    end
  end

endmodule

// ===== rtl/core/bdma_serial_mac.sv =====
// ----------------------------------------------------------------------------
// BLER-driven MCS adapter: serial filter accumulator
// Forms w*old + (1-w)*window bit-serially, one bit of w and one bit of the
// window ratio per cycle, and rounds the sum back to Q0.16.
// ----------------------------------------------------------------------------
module bdma_serial_mac (
  input  logic                         clk,
  input  bdma_pkg::ser_ctrl_t          ctrl,
  input  logic [bdma_pkg::Q_BITS-1:0]  weight,
  input  logic [bdma_pkg::Q_BITS-1:0]  bler_old,
  input  logic                         qbit,
  output logic [bdma_pkg::Q_BITS-1:0]  bler_new
);

  logic [bdma_pkg::ACC_W-1:0]  acc;
  logic [bdma_pkg::Q_BITS-1:0] w_sr;
  logic [bdma_pkg::Q_BITS-1:0] old_r;
  logic [bdma_pkg::Q_BITS:0]   w_comp;
  logic [bdma_pkg::ACC_W-1:0]  acc_next;
  logic [bdma_pkg::ACC_W-1:0]  rounded;

  always_comb begin
    acc_next = {acc[bdma_pkg::ACC_W-2:0], 1'b0};
    if (w_sr[bdma_pkg::Q_BITS-1]) begin
      acc_next = acc_next + bdma_pkg::ACC_W'(old_r);
    end
    if (qbit) begin
      acc_next = acc_next + bdma_pkg::ACC_W'(w_comp);
    end
  end

  assign rounded  = acc + bdma_pkg::ROUND_HALF;
  assign bler_new = rounded[bdma_pkg::ACC_W-1:bdma_pkg::Q_BITS];

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      acc    <= '0;
      w_sr   <= weight;
      old_r  <= bler_old;
      w_comp <= bdma_pkg::ONE_Q16 - {1'b0, weight};
    end else if (ctrl.step) begin
      acc  <= acc_next;
      w_sr <= {w_sr[bdma_pkg::Q_BITS-2:0], 1'b0};
    end
  end

endmodule

// ===== bench/tb_bler_driven_mcs_adapter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the BLER-driven MCS adapter
// A short directed table is followed by long runs of random frame reports,
// mostly well-formed, with frames advancing near the update interval and
// counters rising at a drifting error rate. Each result is compared with
// an in-bench link adaptation predictor or a pinned value. Register settings
// change between phases, and both handshake sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_bler_driven_mcs_adapter;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_LEN = 300;
  localparam int SEGMENT_ITEMS = 217;

  typedef struct packed {
    logic [bdma_pkg::MCS_W-1:0]  mcs;
    logic                        upd;
    logic [bdma_pkg::Q_BITS-1:0] bler;
  } mcs_advice_t;

  typedef struct packed {
    logic                             is_cfg;
    bdma_pkg::reg_idx_t               idx;
    logic [31:0]                      value;
    logic [bdma_pkg::FRAME_W-1:0]     frame;
    logic [bdma_pkg::MCS_W-1:0]       ceil;
    logic [bdma_pkg::COUNT_WIDTH-1:0] sched;
    logic [bdma_pkg::COUNT_WIDTH-1:0] retx;
    logic                             pinned;
    mcs_advice_t                      pin;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [bdma_pkg::PADDR_W-1:0] paddr = '0;
  logic [bdma_pkg::PDATA_W-1:0] pwdata = '0;
  logic [bdma_pkg::PDATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [bdma_pkg::FRAME_W-1:0] frame_number = '0;
  logic [bdma_pkg::MCS_W-1:0] mcs_ceiling = '0;
  logic [bdma_pkg::COUNT_WIDTH-1:0] sched_count = '0;
  logic [bdma_pkg::COUNT_WIDTH-1:0] retx_count = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [bdma_pkg::MCS_W-1:0] mcs_out;
  logic was_updated;
  logic [bdma_pkg::Q_BITS-1:0] bler_average;

  logic drv_pinned = 1'b0;
  mcs_advice_t drv_pin = '0;

  logic [bdma_pkg::FRAME_W-1:0] lu_frame;
  logic [bdma_pkg::MCS_W-1:0] cur_mcs;
  logic [bdma_pkg::Q_BITS-1:0] fbler;
  logic [bdma_pkg::COUNT_WIDTH-1:0] sched_snap, retx_snap;
  logic [bdma_pkg::Q_BITS-1:0] cfg_lower, cfg_upper, cfg_weight;
  logic [bdma_pkg::MCS_W-1:0] cfg_cap;
  logic [bdma_pkg::FRAME_W-1:0] cfg_interval;

  mcs_advice_t advice_q[$];
  stim_row_t dir_rows[$];
  int n_accepted = 0;
  int n_cfg_writes = 0;
  int n_checked = 0;
  int n_updates = 0;
  int n_mismatch = 0;
  int cycle_cnt = 0;
  int tx_idle_pct = 30;
  int rx_idle_pct = 76;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quality = 0;
  logic [bdma_pkg::FRAME_W-1:0] frame_r = '0;
  logic [bdma_pkg::COUNT_WIDTH-1:0] sched_r = '0;
  logic [bdma_pkg::COUNT_WIDTH-1:0] retx_r = '0;

  bler_driven_mcs_adapter uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .frame_number(frame_number), .mcs_ceiling(mcs_ceiling),
    .sched_count(sched_count), .retx_count(retx_count),
    .out_valid(out_valid), .out_ready(out_ready),
    .mcs_out(mcs_out), .was_updated(was_updated), .bler_average(bler_average)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("bler_driven_mcs_adapter: mismatch");
      $finish;
    end
  end

  function automatic mcs_advice_t adapt_link(
      input logic [bdma_pkg::FRAME_W-1:0] frame,
      input logic [bdma_pkg::MCS_W-1:0] ceil_in,
      input logic [bdma_pkg::COUNT_WIDTH-1:0] sched,
      input logic [bdma_pkg::COUNT_WIDTH-1:0] retx);
    logic [bdma_pkg::FRAME_W-1:0] gap;
    logic [bdma_pkg::MCS_W-1:0] cap, old, nmcs;
    logic [bdma_pkg::COUNT_WIDTH-1:0] ns, nr;
    logic [bdma_pkg::Q_BITS-1:0] win;
    logic ns_pos, active;
    logic [63:0] acc;
    mcs_advice_t res;
    if (lu_frame == '0 && cur_mcs == '0) begin
      lu_frame = frame;
      cur_mcs = bdma_pkg::SEED_MCS;
      fbler = bdma_pkg::Q_BITS'((17'(cfg_lower) + 17'(cfg_upper)) >> 1);
    end
    gap = frame - lu_frame;
    cap = (ceil_in < cfg_cap) ? ceil_in : cfg_cap;
    old = (cur_mcs < cap) ? cur_mcs : cap;
    if (gap < cfg_interval) begin
      res = '{mcs: old, upd: 1'b0, bler: fbler};
      return res;
    end
    ns = sched - sched_snap;
    nr = retx - retx_snap;
    ns_pos = !ns[bdma_pkg::COUNT_WIDTH-1] && ns != '0;
    active = ns_pos && ns > bdma_pkg::MIN_ACTIVITY;
    if (!ns_pos) begin
      win = fbler;
    end else if (nr[bdma_pkg::COUNT_WIDTH-1]) begin
      win = bdma_pkg::WIN_ZERO;
    end else if (nr >= ns) begin
      win = bdma_pkg::WIN_SAT;
    end else begin
      acc = (64'(nr) << bdma_pkg::Q_BITS) / 64'(ns);
      win = acc[bdma_pkg::Q_BITS-1:0];
    end
    acc = 64'(cfg_weight) * fbler + (64'd65536 - cfg_weight) * win + 64'd32768;
    fbler = acc[2*bdma_pkg::Q_BITS-1:bdma_pkg::Q_BITS];
    nmcs = old;
    if (fbler < cfg_lower && old < cap && active) begin
      nmcs = old + 1'b1;
    end else if ((fbler > cfg_upper && old > bdma_pkg::MCS_FLOOR) ||
                 (!active && old > bdma_pkg::SEED_MCS)) begin
      nmcs = old - 1'b1;
    end
    lu_frame = frame;
    cur_mcs = nmcs;
    sched_snap = sched;
    retx_snap = retx;
    res = '{mcs: nmcs, upd: 1'b1, bler: fbler};
    return res;
  endfunction

  always @(posedge clk) begin
    mcs_advice_t want;
    if (rst) begin
      lu_frame = '0;
      cur_mcs = '0;
      fbler = '0;
      sched_snap = '0;
      retx_snap = '0;
      cfg_lower = bdma_pkg::RST_BLER_LOWER;
      cfg_upper = bdma_pkg::RST_BLER_UPPER;
      cfg_cap = bdma_pkg::RST_MCS_CAP;
      cfg_interval = bdma_pkg::RST_UPDATE_INTERVAL;
      cfg_weight = bdma_pkg::RST_FILTER_WEIGHT;
      advice_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        n_cfg_writes++;
        case (bdma_pkg::reg_idx_t'(paddr[bdma_pkg::PADDR_W-1:2]))
          bdma_pkg::REG_BLER_LOWER:      cfg_lower = pwdata[bdma_pkg::Q_BITS-1:0];
          bdma_pkg::REG_BLER_UPPER:      cfg_upper = pwdata[bdma_pkg::Q_BITS-1:0];
          bdma_pkg::REG_MCS_CAP:         cfg_cap = pwdata[bdma_pkg::MCS_W-1:0];
          bdma_pkg::REG_UPDATE_INTERVAL: cfg_interval = pwdata[bdma_pkg::FRAME_W-1:0];
          bdma_pkg::REG_FILTER_WEIGHT:   cfg_weight = pwdata[bdma_pkg::Q_BITS-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        n_checked++;
        if (was_updated === 1'b1) n_updates++;
        if (advice_q.size() == 0) begin
          $error("result item arrived with no item pending");
          n_mismatch++;
        end else begin
          want = advice_q.pop_front();
          if (mcs_out !== want.mcs) begin
            $error("mcs_out: expected %0d, got %0d", want.mcs, mcs_out);
            n_mismatch++;
          end
          if (was_updated !== want.upd) begin
            $error("was_updated: expected %0d, got %0d", want.upd, was_updated);
            n_mismatch++;
          end
          if (bler_average !== want.bler) begin
            $error("bler_average: expected %0d, got %0d", want.bler, bler_average);
            n_mismatch++;
          end
        end
      end
      if (in_valid && in_ready) begin
        n_accepted++;
        want = adapt_link(frame_number, mcs_ceiling, sched_count, retx_count);
        advice_q.push_back(drv_pinned ? drv_pin : want);
      end
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_asks != hold_seen) begin
      hold_seen <= hold_asks;
      hold_left <= HOLD_LEN;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic stim_row_t item_row(input logic [bdma_pkg::FRAME_W-1:0] f,
                                         input logic [bdma_pkg::MCS_W-1:0] c,
                                         input logic [bdma_pkg::COUNT_WIDTH-1:0] s,
                                         input logic [bdma_pkg::COUNT_WIDTH-1:0] r);
    stim_row_t row;
    row = '0;
    row.frame = f;
    row.ceil = c;
    row.sched = s;
    row.retx = r;
    return row;
  endfunction

  function automatic stim_row_t pin_row(input logic [bdma_pkg::FRAME_W-1:0] f,
                                        input logic [bdma_pkg::MCS_W-1:0] c,
                                        input logic [bdma_pkg::MCS_W-1:0] m,
                                        input logic [bdma_pkg::Q_BITS-1:0] b);
    stim_row_t row;
    row = item_row(f, c, '0, '0);
    row.pinned = 1'b1;
    row.pin = '{mcs: m, upd: 1'b0, bler: b};
    return row;
  endfunction

  function automatic stim_row_t cfg_row(input bdma_pkg::reg_idx_t idx,
                                        input logic [31:0] v);
    stim_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.value = v;
    return row;
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (advice_q.size() != 0);
  endtask

  task automatic cfg_write(input bdma_pkg::reg_idx_t idx, input logic [31:0] value);
    int target;
    wait_drained();
    target = n_cfg_writes + 1;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= bdma_pkg::PADDR_W'({idx, 2'b00});
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (n_cfg_writes != target);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic offer_report(input logic [bdma_pkg::FRAME_W-1:0] f,
                              input logic [bdma_pkg::MCS_W-1:0] c,
                              input logic [bdma_pkg::COUNT_WIDTH-1:0] s,
                              input logic [bdma_pkg::COUNT_WIDTH-1:0] r,
                              input logic pinned, input mcs_advice_t pin);
    int target;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    target = n_accepted + 1;
    in_valid <= 1'b1;
    frame_number <= f;
    mcs_ceiling <= c;
    sched_count <= s;
    retx_count <= r;
    drv_pinned <= pinned;
    drv_pin <= pin;
    do @(negedge clk); while (n_accepted != target);
  endtask

  task automatic program_link(input int k);
    int lo, hi, cap, iv, w;
    lo = $urandom_range(0, 16000);
    hi = lo + $urandom_range(0, 30000);
    cap = $urandom_range(8, 31);
    iv = $urandom_range(1, 12);
    w = $urandom_range(20000, 65535);
    case (k)
      0: begin
        lo = bdma_pkg::RST_BLER_LOWER;
        hi = bdma_pkg::RST_BLER_UPPER;
        cap = bdma_pkg::RST_MCS_CAP;
        iv = bdma_pkg::RST_UPDATE_INTERVAL;
        w = bdma_pkg::RST_FILTER_WEIGHT;
      end
      2: begin
        lo = 65535;
        hi = 65535;
        cap = 31;
        iv = 1;
        w = 0;
      end
      3: begin
        lo = 0;
        hi = 0;
        iv = 0;
        w = 65535;
      end
      5: cap = 0;
      default: ;
    endcase
    cfg_write(bdma_pkg::REG_BLER_LOWER, lo);
    cfg_write(bdma_pkg::REG_BLER_UPPER, hi);
    cfg_write(bdma_pkg::REG_MCS_CAP, cap);
    cfg_write(bdma_pkg::REG_UPDATE_INTERVAL, iv);
    cfg_write(bdma_pkg::REG_FILTER_WEIGHT, w);
  endtask

  task automatic run_random(input int count);
    int fstep, sinc, rinc;
    logic [bdma_pkg::MCS_W-1:0] ceil_v;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) quality = $urandom_range(0, 40);
      if ($urandom_range(99) < 12) begin
        frame_r = bdma_pkg::FRAME_W'($urandom);
        sched_r = $urandom;
        retx_r = $urandom;
        ceil_v = bdma_pkg::MCS_W'($urandom);
      end else begin
        if ($urandom_range(3) == 0) fstep = $urandom_range(0, cfg_interval);
        else fstep = cfg_interval + $urandom_range(0, 2);
        frame_r = frame_r + bdma_pkg::FRAME_W'(fstep);
        sinc = ($urandom_range(4) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 80);
        rinc = $urandom_range(0, sinc * quality / 64);
        sched_r = sched_r + sinc;
        retx_r = retx_r + rinc;
        ceil_v = ($urandom_range(3) == 0) ? bdma_pkg::MCS_W'($urandom)
                                          : bdma_pkg::MCS_W'(31);
      end
      offer_report(frame_r, ceil_v, sched_r, retx_r, 1'b0, '0);
    end
  endtask

  initial begin
    dir_rows.push_back(pin_row(10'd100, 5'd31, bdma_pkg::SEED_MCS, 16'd6553));
    dir_rows.push_back(pin_row(10'd105, 5'd0, 5'd0, 16'd6553));
    dir_rows.push_back(item_row(10'd110, 5'd31, 32'd100, 32'd0));
    dir_rows.push_back(item_row(10'd120, 5'd31, 32'd200, 32'd100));
    dir_rows.push_back(item_row(10'd130, 5'd31, 32'd300, 32'd300));
    dir_rows.push_back(item_row(10'd140, 5'd31, 32'd400, 32'd400));
    dir_rows.push_back(item_row(10'd150, 5'd31, 32'd400, 32'd400));
    dir_rows.push_back(item_row(10'd160, 5'd31, 32'd402, 32'd400));
    dir_rows.push_back(item_row(10'd170, 5'd31, 32'd500, 32'd300));
    dir_rows.push_back(item_row(10'd180, 5'd31, 32'hFFFF_FFF0, 32'd300));
    dir_rows.push_back(item_row(10'd190, 5'd31, 32'h0000_0010, 32'hFFFF_FFFF));
    dir_rows.push_back(item_row(10'd5, 5'd31, 32'h0000_0030, 32'h0000_0000));
    dir_rows.push_back(cfg_row(bdma_pkg::REG_UPDATE_INTERVAL, 32'd0));
    dir_rows.push_back(item_row(10'd5, 5'd31, 32'h0000_0030, 32'd0));
    dir_rows.push_back(cfg_row(bdma_pkg::REG_UPDATE_INTERVAL, 32'd1023));
    dir_rows.push_back(item_row(10'd6, 5'd31, 32'd100, 32'd10));
    dir_rows.push_back(item_row(10'd4, 5'd31, 32'd200, 32'd20));
    dir_rows.push_back(cfg_row(bdma_pkg::REG_FILTER_WEIGHT, 32'd0));
    dir_rows.push_back(item_row(10'd3, 5'd31, 32'd300, 32'd30));
    dir_rows.push_back(cfg_row(bdma_pkg::REG_FILTER_WEIGHT, 32'd65535));
    dir_rows.push_back(cfg_row(bdma_pkg::REG_UPDATE_INTERVAL, 32'd1));
    dir_rows.push_back(cfg_row(bdma_pkg::REG_MCS_CAP, 32'd0));
    dir_rows.push_back(item_row(10'd1023, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    dir_rows.push_back(cfg_row(bdma_pkg::REG_MCS_CAP, 32'd31));
    dir_rows.push_back(cfg_row(bdma_pkg::REG_BLER_LOWER, 32'd65535));
    dir_rows.push_back(item_row(10'd0, 5'd31, 32'd40, 32'd0));

    repeat (5) @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        cfg_write(dir_rows[i].idx, dir_rows[i].value);
      end else begin
        offer_report(dir_rows[i].frame, dir_rows[i].ceil, dir_rows[i].sched,
                     dir_rows[i].retx, dir_rows[i].pinned, dir_rows[i].pin);
      end
    end

    for (int k = 0; k < 6; k++) begin
      program_link(k);
      case (k / 2)
        0: begin
          tx_idle_pct = 30;
          rx_idle_pct <= 76;
        end
        1: begin
          tx_idle_pct = 76;
          rx_idle_pct <= 30;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct <= 0;
        end
      endcase
      if (k == 4) hold_asks <= hold_asks + 1;
      run_random(SEGMENT_ITEMS);
    end

    wait_drained();
    repeat (40) @(negedge clk);

    $display("Sent %0d items over six register settings and three idle patterns.",
             n_accepted);
    $display("Checked %0d results, %0d of them filter updates.", n_checked, n_updates);
    if (n_mismatch == 0) begin
      $display("bler_driven_mcs_adapter: match");
    end else begin
      $display("bler_driven_mcs_adapter: mismatch");
    end
    $finish;
  end

endmodule
